### rtl/spv_pkg.sv
// Shared types, codes and prefix tables for the storage path validator.
// Used by every module under rtl/; depends on nothing else.

package spv_pkg;

  // One input byte request as it travels through the block.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       empty_path;
  } spv_item_t;

  // Error codes in verdict priority order.
  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_EMPTY    = 3'd1,
    ERR_ABSOLUTE = 3'd2,
    ERR_NO_LABEL = 3'd3,
    ERR_TRAIL    = 3'd4,
    ERR_DSLASH   = 3'd5,
    ERR_DOTDOT   = 3'd6,
    ERR_DOT      = 3'd7
  } spv_err_t;

  // One verdict request.
  typedef struct packed {
    logic [2:0] tail_start;
    logic [1:0] label_index;
    spv_err_t   error_code;
  } spv_result_t;

  // Tail component tracking.
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_DOT   = 2'd1,
    PH_DDOT  = 2'd2,
    PH_PLAIN = 2'd3
  } spv_phase_t;

  // First offending component seen in the tail.
  typedef enum logic [1:0] {
    BAD_NONE = 2'd0,
    BAD_DDOT = 2'd1,
    BAD_DOT  = 2'd2,
    BAD_RSVD = 2'd3
  } spv_bad_t;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [2:0] POS_MAX  = 3'd7;
  localparam logic [2:0] CAND_ALL = 3'b111;

  // Label indexes.
  localparam logic [1:0] LBL_HOME   = 2'd0;
  localparam logic [1:0] LBL_ROOT   = 2'd1;
  localparam logic [1:0] LBL_CUSTOM = 2'd2;

  // Length of each label prefix, slash included.
  function automatic logic [2:0] prefix_len(input logic [1:0] lbl);
    logic [2:0] len;
    case (lbl)
      LBL_HOME:   len = 3'd5;
      LBL_ROOT:   len = 3'd5;
      LBL_CUSTOM: len = 3'd7;
      default:    len = 3'd0;
    endcase
    return len;
  endfunction

  // Expected byte of a label prefix at a given offset.
  function automatic logic [7:0] prefix_char(input logic [1:0] lbl, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (lbl)
      LBL_HOME: begin
        case (pos)
          3'd0:    ch = "h";
          3'd1:    ch = "o";
          3'd2:    ch = "m";
          3'd3:    ch = "e";
          3'd4:    ch = "/";
          default: ch = 8'h00;
        endcase
      end
      LBL_ROOT: begin
        case (pos)
          3'd0:    ch = "r";
          3'd1:    ch = "o";
          3'd2:    ch = "o";
          3'd3:    ch = "t";
          3'd4:    ch = "/";
          default: ch = 8'h00;
        endcase
      end
      LBL_CUSTOM: begin
        case (pos)
          3'd0:    ch = "c";
          3'd1:    ch = "u";
          3'd2:    ch = "s";
          3'd3:    ch = "t";
          3'd4:    ch = "o";
          3'd5:    ch = "m";
          3'd6:    ch = "/";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

### rtl/spv_in_stage.sv
// Input register of the storage path validator: holds one byte request.
// Depends on spv_pkg.

module spv_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spv_pkg::spv_item_t in_item,
  output logic               item_valid,
  output spv_pkg::spv_item_t item,
  input  logic               item_advance
);

  logic               valid_r;
  logic               valid_nxt;
  spv_pkg::spv_item_t item_r;

  // Take a new request whenever the held one leaves or none is held.
  assign in_ready  = !valid_r || item_advance;
  assign valid_nxt = in_valid ? 1'b1 : (valid_r && !item_advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### rtl/spv_step.sv
// Path state and per-byte update logic of the storage path validator.
// Depends on spv_pkg.

module spv_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  spv_pkg::spv_item_t   item,
  output logic                 res_valid,
  output spv_pkg::spv_result_t res
);

  logic [2:0]          pos_r,   pos_nxt;
  logic [2:0]          cand_r,  cand_nxt;
  logic [1:0]          label_r, label_nxt;
  logic                pm_r,    pm_nxt;
  logic                sws_r,   sws_nxt;
  logic                pws_r,   pws_nxt;
  logic                sds_r,   sds_nxt;
  spv_pkg::spv_phase_t phase_r, phase_nxt;
  spv_pkg::spv_bad_t   bad_r,   bad_nxt;

  logic slash;
  logic dot;
  logic ends;

  assign slash     = (item.char_code == spv_pkg::CH_SLASH);
  assign dot       = (item.char_code == spv_pkg::CH_DOT);
  assign ends      = item.last_char || item.empty_path;
  assign res_valid = fire && ends;

  // Next state for one non-empty byte.
  always_comb begin
    logic done;
    logic hit;
    done      = 1'b0;
    hit       = 1'b0;
    pos_nxt   = (pos_r < spv_pkg::POS_MAX) ? pos_r + 3'd1 : pos_r;
    cand_nxt  = cand_r;
    label_nxt = label_r;
    pm_nxt    = pm_r;
    sws_nxt   = sws_r || ((pos_r == 3'd0) && slash);
    pws_nxt   = slash;
    sds_nxt   = sds_r || (pws_r && slash);
    phase_nxt = phase_r;
    bad_nxt   = bad_r;

    if (pm_r) begin
      // Walk the tail components.
      unique case (phase_r)
        spv_pkg::PH_START: begin
          phase_nxt = slash ? spv_pkg::PH_START :
                      (dot ? spv_pkg::PH_DOT : spv_pkg::PH_PLAIN);
        end
        spv_pkg::PH_DOT: begin
          if (slash) begin
            if (bad_r == spv_pkg::BAD_NONE) bad_nxt = spv_pkg::BAD_DOT;
            phase_nxt = spv_pkg::PH_START;
          end else begin
            phase_nxt = dot ? spv_pkg::PH_DDOT : spv_pkg::PH_PLAIN;
          end
        end
        spv_pkg::PH_DDOT: begin
          if (slash) begin
            if (bad_r == spv_pkg::BAD_NONE) bad_nxt = spv_pkg::BAD_DDOT;
            phase_nxt = spv_pkg::PH_START;
          end else begin
            phase_nxt = spv_pkg::PH_PLAIN;
          end
        end
        default: begin
          phase_nxt = slash ? spv_pkg::PH_START : spv_pkg::PH_PLAIN;
        end
      endcase
    end else if (pos_r < spv_pkg::POS_MAX) begin
      // Compare against each label still in the running.
      for (int k = 0; k < 3; k++) begin
        if (!done && cand_r[k]) begin
          hit = (pos_r < spv_pkg::prefix_len(2'(k))) &&
                (item.char_code == spv_pkg::prefix_char(2'(k), pos_r));
          if (hit) begin
            if (pos_r == spv_pkg::prefix_len(2'(k)) - 3'd1) begin
              pm_nxt    = 1'b1;
              label_nxt = 2'(k);
              cand_nxt  = 3'b000;
              done      = 1'b1;
            end
          end else begin
            cand_nxt[k] = 1'b0;
          end
        end
      end
    end

    // An open dot component at the end of the path counts too.
    if (item.last_char && pm_nxt && (bad_nxt == spv_pkg::BAD_NONE)) begin
      if (phase_nxt == spv_pkg::PH_DOT) begin
        bad_nxt = spv_pkg::BAD_DOT;
      end else if (phase_nxt == spv_pkg::PH_DDOT) begin
        bad_nxt = spv_pkg::BAD_DDOT;
      end
    end
  end

  // Verdict in priority order.
  always_comb begin
    res.label_index = pm_nxt ? label_nxt : 2'd0;
    res.tail_start  = pm_nxt ? spv_pkg::prefix_len(label_nxt) : 3'd0;
    if (item.empty_path) begin
      res.error_code  = spv_pkg::ERR_EMPTY;
      res.label_index = 2'd0;
      res.tail_start  = 3'd0;
    end else if (sws_nxt) begin
      res.error_code = spv_pkg::ERR_ABSOLUTE;
    end else if (!pm_nxt) begin
      res.error_code = spv_pkg::ERR_NO_LABEL;
    end else if (slash) begin
      res.error_code = spv_pkg::ERR_TRAIL;
    end else if (sds_nxt) begin
      res.error_code = spv_pkg::ERR_DSLASH;
    end else if (bad_nxt == spv_pkg::BAD_DDOT) begin
      res.error_code = spv_pkg::ERR_DOTDOT;
    end else if (bad_nxt == spv_pkg::BAD_DOT) begin
      res.error_code = spv_pkg::ERR_DOT;
    end else begin
      res.error_code = spv_pkg::ERR_OK;
    end
  end

  // State registers; everything clears at the end of each path.
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && ends)) begin
      pos_r   <= 3'd0;
      cand_r  <= spv_pkg::CAND_ALL;
      label_r <= 2'd0;
      pm_r    <= 1'b0;
      sws_r   <= 1'b0;
      pws_r   <= 1'b0;
      sds_r   <= 1'b0;
      phase_r <= spv_pkg::PH_START;
      bad_r   <= spv_pkg::BAD_NONE;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      cand_r  <= cand_nxt;
      label_r <= label_nxt;
      pm_r    <= pm_nxt;
      sws_r   <= sws_nxt;
      pws_r   <= pws_nxt;
      sds_r   <= sds_nxt;
      phase_r <= phase_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

### rtl/spv_out_stage.sv
// Result register of the storage path validator: holds one verdict request.
// Depends on spv_pkg.

module spv_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  spv_pkg::spv_result_t res,
  output logic                 res_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output spv_pkg::spv_result_t out_res
);

  logic                 valid_r;
  spv_pkg::spv_result_t res_r;

  // The slot is free when empty or being drained this cycle.
  assign res_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_free) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### rtl/storage_path_validator.sv
// Storage path validator top level: one path byte per cycle while the result slot has room, one verdict per path.
// The verdict is captured in the result register of spv_out_stage when the final byte leaves the input register.
// A byte that ends a path waits in the input register while the result slot is full.
// Reset: synchronous, active low; clears both stage valids and all path state.
// Depends on spv_pkg, spv_in_stage, spv_step and spv_out_stage.

module storage_path_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // last_char
  input  logic       in_tuser,   // empty_path
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [2:0] error_code, [4:3] label_index, [7:5] tail_start
);

  spv_pkg::spv_item_t   in_item;
  spv_pkg::spv_item_t   item;
  spv_pkg::spv_result_t res;
  spv_pkg::spv_result_t out_res;
  logic                 item_valid;
  logic                 item_advance;
  logic                 res_valid;
  logic                 res_free;

  assign in_item.char_code  = in_tdata;
  assign in_item.last_char  = in_tlast;
  assign in_item.empty_path = in_tuser;

  // A held byte moves on unless it ends a path and the result slot is full.
  assign item_advance = item_valid &&
                        (!(item.last_char || item.empty_path) || res_free);

  spv_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_item      (in_item),
    .item_valid   (item_valid),
    .item         (item),
    .item_advance (item_advance)
  );

  spv_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (item_advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  spv_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.tail_start, out_res.label_index, out_res.error_code};

endmodule
